// File: src/rta_pkg.sv
// Shared types, palette table and threshold rules for the RGB to text attribute block.
package rta_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int CH_W      = 8;
    localparam int RGB_W     = 3 * CH_W;
    localparam int DIST_W    = 19;
    localparam int IN_W      = 48;
    localparam int OUT_W     = 16;

    localparam logic [RGB_W-1:0] PALETTE [NUM_SLOTS] = '{
        24'h0F1419, 24'h007ACC, 24'h6A9955, 24'h4EC9B0,
        24'hCE9178, 24'hC586C0, 24'hD7BA7D, 24'hF5F5F5,
        24'h5C6773, 24'h569CD6, 24'hD7BA7D, 24'h39BAE6,
        24'hF44747, 24'hD4BFFF, 24'hFF8F40, 24'hFFFFFF
    };

    typedef logic [NUM_SLOTS-1:0][DIST_W-1:0] t_dist_vec;

    typedef struct packed {
        logic ld_in;
        logic ld_sq;
        logic ld_sum;
        logic ld_tree;
        logic ld_out;
    } t_pipe_en;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } t_rule;

    function automatic t_rule rule_slot(input logic [CH_W-1:0] r,
                                        input logic [CH_W-1:0] g,
                                        input logic [CH_W-1:0] b);
        logic [9:0] rr;
        logic [9:0] gg;
        logic [9:0] bb;
        logic [9:0] bri;
        t_rule      res;
        rr  = {2'b00, r};
        gg  = {2'b00, g};
        bb  = {2'b00, b};
        bri = rr + gg + bb;
        res.hit = 1'b1;
        if (rr < 10'd40 && gg < 10'd40 && bb < 10'd45) begin
            res.slot = 4'd0;
        end else if (bri > 10'd40 && bri < 10'd140 && rr < 10'd55 && gg < 10'd60
                     && bb < 10'd70 && !(rr < 10'd40 && gg < 10'd40)) begin
            res.slot = 4'd8;
        end else if (rr > 10'd200 && gg > 10'd200 && bb > 10'd200) begin
            res.slot = 4'd15;
        end else if (rr > 10'd180 && gg > 10'd180 && bb > 10'd180) begin
            res.slot = 4'd7;
        end else if (gg > 10'd140 && bb > 10'd140 && rr < 10'd130
                     && bb + 10'd40 >= gg) begin
            res.slot = 4'd3;
        end else if (bb > 10'd170 && rr < 10'd130 && gg > 10'd100 && gg < 10'd210) begin
            res.slot = 4'd9;
        end else if (bb > rr + 10'd30 && bb > gg && rr < 10'd120) begin
            res.slot = 4'd1;
        end else if (gg > rr + 10'd20 && gg > bb + 10'd20 && gg > 10'd100
                     && rr < 10'd160 && bb < 10'd130) begin
            res.slot = 4'd2;
        end else if (rr > 10'd160 && gg > 10'd100 && gg < 10'd180 && bb < 10'd140) begin
            res.slot = 4'd4;
        end else if (rr > 10'd150 && bb > 10'd150 && gg < 10'd160) begin
            res.slot = 4'd5;
        end else if (rr > 10'd180 && gg > 10'd140 && bb < 10'd160 && bb < gg) begin
            res.slot = 4'd10;
        end else if (rr > 10'd150 && gg > 10'd60 && gg < 10'd120 && bb < 10'd50) begin
            res.slot = 4'd14;
        end else if (rr > 10'd200 && gg < 10'd100) begin
            res.slot = 4'd12;
        end else if (rr > 10'd200 && gg > 10'd100 && bb < 10'd100) begin
            res.slot = 4'd14;
        end else begin
            res.hit  = 1'b0;
            res.slot = 4'd0;
        end
        return res;
    endfunction

endpackage

// File: src/rta_lane.sv
// Distance lane: weighted squared distance from one colour to one palette entry.
module rta_lane (
    input  logic                       i_clk,
    input  rta_pkg::t_pipe_en          i_en,
    input  logic [rta_pkg::CH_W-1:0]   i_r,
    input  logic [rta_pkg::CH_W-1:0]   i_g,
    input  logic [rta_pkg::CH_W-1:0]   i_b,
    input  logic [rta_pkg::RGB_W-1:0]  i_pal,
    output logic [rta_pkg::DIST_W-1:0] o_dist
);
    import rta_pkg::*;

    logic signed [8:0]  w_dr;
    logic signed [8:0]  w_dg;
    logic signed [8:0]  w_db;
    logic signed [10:0] w_dbri;
    logic signed [17:0] w_sq_r;
    logic signed [17:0] w_sq_g;
    logic signed [17:0] w_sq_b;
    logic signed [21:0] w_sq_bri;
    logic [15:0]        r_sq_r;
    logic [15:0]        r_sq_g;
    logic [15:0]        r_sq_b;
    logic [19:0]        r_sq_bri;
    logic [DIST_W-1:0]  r_dist;

    assign w_dr   = $signed({1'b0, i_r}) - $signed({1'b0, i_pal[23:16]});
    assign w_dg   = $signed({1'b0, i_g}) - $signed({1'b0, i_pal[15:8]});
    assign w_db   = $signed({1'b0, i_b}) - $signed({1'b0, i_pal[7:0]});
    assign w_dbri = $signed({3'b000, i_r}) + $signed({3'b000, i_g}) + $signed({3'b000, i_b})
                  - $signed({3'b000, i_pal[23:16]}) - $signed({3'b000, i_pal[15:8]})
                  - $signed({3'b000, i_pal[7:0]});

    assign w_sq_r   = 18'(w_dr) * 18'(w_dr);
    assign w_sq_g   = 18'(w_dg) * 18'(w_dg);
    assign w_sq_b   = 18'(w_db) * 18'(w_db);
    assign w_sq_bri = 22'(w_dbri) * 22'(w_dbri);

    always_ff @(posedge i_clk) begin
        if (i_en.ld_sq) begin
            r_sq_r   <= w_sq_r[15:0];
            r_sq_g   <= w_sq_g[15:0];
            r_sq_b   <= w_sq_b[15:0];
            r_sq_bri <= w_sq_bri[19:0];
        end
        if (i_en.ld_sum) begin
            r_dist <= DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b)
                    + DIST_W'(r_sq_bri[19:2]);
        end
    end

    assign o_dist = r_dist;

endmodule

// File: src/rta_merge.sv
// Merge stage: two-step registered first-minimum tree over the lane distances.
module rta_merge (
    input  logic                       i_clk,
    input  rta_pkg::t_pipe_en          i_en,
    input  rta_pkg::t_dist_vec         i_dist,
    input  rta_pkg::t_rule             i_rule,
    output logic [rta_pkg::SLOT_W-1:0] o_slot
);
    import rta_pkg::*;

    logic [7:0][DIST_W-1:0] w_d1;
    logic [7:0][SLOT_W-1:0] w_i1;
    logic [3:0][DIST_W-1:0] w_d2;
    logic [3:0][SLOT_W-1:0] w_i2;
    logic [3:0][DIST_W-1:0] r_d2;
    logic [3:0][SLOT_W-1:0] r_i2;
    t_rule                  r_rule;
    logic [1:0][DIST_W-1:0] w_d3;
    logic [1:0][SLOT_W-1:0] w_i3;
    logic [SLOT_W-1:0]      w_best;
    logic [SLOT_W-1:0]      r_slot;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            if (i_dist[2*k] <= i_dist[2*k+1]) begin
                w_d1[k] = i_dist[2*k];
                w_i1[k] = SLOT_W'(2*k);
            end else begin
                w_d1[k] = i_dist[2*k+1];
                w_i1[k] = SLOT_W'(2*k+1);
            end
        end
        for (int k = 0; k < 4; k++) begin
            if (w_d1[2*k] <= w_d1[2*k+1]) begin
                w_d2[k] = w_d1[2*k];
                w_i2[k] = w_i1[2*k];
            end else begin
                w_d2[k] = w_d1[2*k+1];
                w_i2[k] = w_i1[2*k+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld_tree) begin
            r_d2   <= w_d2;
            r_i2   <= w_i2;
            r_rule <= i_rule;
        end
    end

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            if (r_d2[2*k] <= r_d2[2*k+1]) begin
                w_d3[k] = r_d2[2*k];
                w_i3[k] = r_i2[2*k];
            end else begin
                w_d3[k] = r_d2[2*k+1];
                w_i3[k] = r_i2[2*k+1];
            end
        end
        w_best = (w_d3[0] <= w_d3[1]) ? w_i3[0] : w_i3[1];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld_out) begin
            r_slot <= r_rule.hit ? r_rule.slot : w_best;
        end
    end

    assign o_slot = r_slot;

endmodule

// File: src/rta_pick.sv
// Slot picker for one colour: input register, threshold rules, sixteen distance lanes, merge.
module rta_pick (
    input  logic                       i_clk,
    input  rta_pkg::t_pipe_en          i_en,
    input  logic [rta_pkg::RGB_W-1:0]  i_rgb,
    output logic [rta_pkg::SLOT_W-1:0] o_slot
);
    import rta_pkg::*;

    logic [CH_W-1:0] r_r;
    logic [CH_W-1:0] r_g;
    logic [CH_W-1:0] r_b;
    t_rule           w_rule;
    t_rule           r_rule_sq;
    t_rule           r_rule_sum;
    t_dist_vec       w_dist;

    always_ff @(posedge i_clk) begin
        if (i_en.ld_in) begin
            r_r <= i_rgb[23:16];
            r_g <= i_rgb[15:8];
            r_b <= i_rgb[7:0];
        end
        if (i_en.ld_sq) begin
            r_rule_sq <= w_rule;
        end
        if (i_en.ld_sum) begin
            r_rule_sum <= r_rule_sq;
        end
    end

    assign w_rule = rule_slot(r_r, r_g, r_b);

    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_lane
        rta_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_r    (r_r),
            .i_g    (r_g),
            .i_b    (r_b),
            .i_pal  (PALETTE[k]),
            .o_dist (w_dist[k])
        );
    end

    rta_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_dist (w_dist),
        .i_rule (r_rule_sum),
        .o_slot (o_slot)
    );

endmodule

// File: src/rgb_to_text_attribute.sv
// Top level: maps a foreground/background RGB pair to palette slots and a text attribute.
//
//  channel  dir  fields (low bit up)
//  s_axis   in   fore_rgb[23:0], back_rgb[47:24]
//  m_axis   out  attribute[6:0], fore_slot[10:7], back_slot[14:11], zero[15]
//
//  One item per cycle sustained while the output accepts results.
//  Stages: input register, squares, distance sums, two tree levels with rule select.
//  Reset clears only the stage valid bits.
//  Each stage loads when it is empty or the stage after it loads, so bubbles close
//  up and input is taken while a result waits at the output.
module rgb_to_text_attribute (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [rta_pkg::IN_W-1:0]    i_s_axis_tdata,   // fore_rgb, back_rgb
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [rta_pkg::OUT_W-1:0]   o_m_axis_tdata    // attribute, fore_slot, back_slot
);
    import rta_pkg::*;

    logic [4:0]        r_vld;
    logic [4:0]        n_vld;
    t_pipe_en          w_en;
    logic [SLOT_W-1:0] w_fore;
    logic [SLOT_W-1:0] w_back;

    always_comb begin
        w_en.ld_out  = !r_vld[4] || i_m_axis_tready;
        w_en.ld_tree = !r_vld[3] || w_en.ld_out;
        w_en.ld_sum  = !r_vld[2] || w_en.ld_tree;
        w_en.ld_sq   = !r_vld[1] || w_en.ld_sum;
        w_en.ld_in   = !r_vld[0] || w_en.ld_sq;
        n_vld = r_vld;
        if (w_en.ld_in)   n_vld[0] = i_s_axis_tvalid;
        if (w_en.ld_sq)   n_vld[1] = r_vld[0];
        if (w_en.ld_sum)  n_vld[2] = r_vld[1];
        if (w_en.ld_tree) n_vld[3] = r_vld[2];
        if (w_en.ld_out)  n_vld[4] = r_vld[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    rta_pick u_fore (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rgb  (i_s_axis_tdata[23:0]),
        .o_slot (w_fore)
    );

    rta_pick u_back (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rgb  (i_s_axis_tdata[47:24]),
        .o_slot (w_back)
    );

    assign o_s_axis_tready = w_en.ld_in;
    assign o_m_axis_tvalid = r_vld[4];
    assign o_m_axis_tdata  = {1'b0, w_back, w_fore, w_back[2:0], w_fore};

endmodule

// File: test/testbench.sv
// Testbench for rgb_to_text_attribute: directed and random color pairs vs. a palette predictor.
module testbench;

    import rta_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 20;

    typedef struct packed {
        logic [23:0] fore;
        logic [23:0] back;
        logic        typed;
        logic [3:0]  fore_slot;
        logic [3:0]  back_slot;
    } t_stim_row;

    typedef struct packed {
        logic [6:0] attribute;
        logic [3:0] fore_slot;
        logic [3:0] back_slot;
    } t_attr_result;

    localparam logic [23:0] COLOR_TABLE [16] = '{
        24'h0F1419, 24'h007ACC, 24'h6A9955, 24'h4EC9B0,
        24'hCE9178, 24'hC586C0, 24'hD7BA7D, 24'hF5F5F5,
        24'h5C6773, 24'h569CD6, 24'hD7BA7D, 24'h39BAE6,
        24'hF44747, 24'hD4BFFF, 24'hFF8F40, 24'hFFFFFF
    };

    localparam int NUM_DIRECTED = 25;
    localparam t_stim_row DIRECTED [NUM_DIRECTED] = '{
        '{24'h000000, 24'h000000, 1'b1, 4'd0,  4'd0},
        '{24'hFFFFFF, 24'hFFFFFF, 1'b1, 4'd15, 4'd15},
        '{24'hFFFFFF, 24'h000000, 1'b1, 4'd15, 4'd0},
        '{24'h000000, 24'hFFFFFF, 1'b1, 4'd0,  4'd15},
        '{24'h0F1419, 24'hFFFFFF, 1'b0, 4'd0,  4'd0},
        '{24'h007ACC, 24'hFF8F40, 1'b0, 4'd0,  4'd0},
        '{24'h6A9955, 24'hD4BFFF, 1'b0, 4'd0,  4'd0},
        '{24'h4EC9B0, 24'hF44747, 1'b0, 4'd0,  4'd0},
        '{24'hCE9178, 24'h39BAE6, 1'b0, 4'd0,  4'd0},
        '{24'hC586C0, 24'hD7BA7D, 1'b0, 4'd0,  4'd0},
        '{24'hD7BA7D, 24'h569CD6, 1'b0, 4'd0,  4'd0},
        '{24'hF5F5F5, 24'h5C6773, 1'b0, 4'd0,  4'd0},
        '{24'h5C6773, 24'hF5F5F5, 1'b0, 4'd0,  4'd0},
        '{24'h569CD6, 24'hD7BA7D, 1'b0, 4'd0,  4'd0},
        '{24'hD7BA7D, 24'hC586C0, 1'b0, 4'd0,  4'd0},
        '{24'h39BAE6, 24'hCE9178, 1'b0, 4'd0,  4'd0},
        '{24'hF44747, 24'h4EC9B0, 1'b0, 4'd0,  4'd0},
        '{24'hD4BFFF, 24'h6A9955, 1'b0, 4'd0,  4'd0},
        '{24'hFF8F40, 24'h007ACC, 1'b0, 4'd0,  4'd0},
        '{24'hFFFFFF, 24'h0F1419, 1'b0, 4'd0,  4'd0},
        '{24'h808080, 24'hD7BA7D, 1'b0, 4'd0,  4'd0},
        '{24'hFF0000, 24'h00FF00, 1'b0, 4'd0,  4'd0},
        '{24'h0000FF, 24'h282828, 1'b0, 4'd0,  4'd0},
        '{24'h272727, 24'h2A2A2A, 1'b0, 4'd0,  4'd0},
        '{24'hC8C8C8, 24'hB5B5B5, 1'b0, 4'd0,  4'd0}
    };

    localparam int EDGE_VALUES [17] = '{
        0, 40, 45, 55, 60, 70, 100, 120, 130, 140, 150, 160, 170, 180, 200, 210, 255
    };

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic [IN_W-1:0]   s_tdata  = '0;
    logic              s_tready;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    t_attr_result pending_attrs [$];
    int           error_count = 0;
    int           send_burst  = 0;
    int           recv_burst  = 0;

    rgb_to_text_attribute DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    initial begin
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    function automatic logic [3:0] nearest_slot(input logic [23:0] rgb);
        int r;
        int g;
        int b;
        int bri;
        int best_dist;
        int cand_dist;
        int dr;
        int dg;
        int db;
        int dbri;
        logic [3:0] best;
        r   = int'(rgb[23:16]);
        g   = int'(rgb[15:8]);
        b   = int'(rgb[7:0]);
        bri = r + g + b;
        if (r < 40 && g < 40 && b < 45) return 4'd0;
        if (bri > 40 && bri < 140 && r < 55 && g < 60 && b < 70 && !(r < 40 && g < 40))
            return 4'd8;
        if (r > 200 && g > 200 && b > 200) return 4'd15;
        if (r > 180 && g > 180 && b > 180) return 4'd7;
        if (g > 140 && b > 140 && r < 130 && b + 40 >= g) return 4'd3;
        if (b > 170 && r < 130 && g > 100 && g < 210) return 4'd9;
        if (b > r + 30 && b > g && r < 120) return 4'd1;
        if (g > r + 20 && g > b + 20 && g > 100 && r < 160 && b < 130) return 4'd2;
        if (r > 160 && g > 100 && g < 180 && b < 140) return 4'd4;
        if (r > 150 && b > 150 && g < 160) return 4'd5;
        if (r > 180 && g > 140 && b < 160 && b < g) return 4'd10;
        if (r > 150 && g > 60 && g < 120 && b < 50) return 4'd14;
        if (r > 200 && g < 100) return 4'd12;
        if (r > 200 && g > 100 && b < 100) return 4'd14;
        best_dist = 32'h7fffffff;
        best      = 4'd0;
        for (int k = 0; k < 16; k++) begin
            dr   = r - int'(COLOR_TABLE[k][23:16]);
            dg   = g - int'(COLOR_TABLE[k][15:8]);
            db   = b - int'(COLOR_TABLE[k][7:0]);
            dbri = bri - (int'(COLOR_TABLE[k][23:16]) + int'(COLOR_TABLE[k][15:8])
                          + int'(COLOR_TABLE[k][7:0]));
            cand_dist = dr * dr + dg * dg + db * db + (dbri * dbri) / 4;
            if (cand_dist < best_dist) begin
                best_dist = cand_dist;
                best      = 4'(k);
            end
        end
        return best;
    endfunction

    function automatic logic [7:0] clamp_channel(input int v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return 8'(v);
    endfunction

    function automatic logic [23:0] random_color();
        int mode;
        logic [7:0] ch [3];
        logic [23:0] base;
        mode = $urandom_range(0, 9);
        if (mode <= 2) begin
            return 24'($urandom());
        end else if (mode <= 5) begin
            for (int i = 0; i < 3; i++)
                ch[i] = clamp_channel(EDGE_VALUES[$urandom_range(0, 16)]
                                      + $urandom_range(0, 4) - 2);
        end else if (mode <= 7) begin
            base = COLOR_TABLE[$urandom_range(0, 15)];
            for (int i = 0; i < 3; i++)
                ch[i] = clamp_channel(int'(base[8*i +: 8]) + $urandom_range(0, 16) - 8);
        end else if (mode == 8) begin
            for (int i = 0; i < 3; i++)
                ch[i] = 8'($urandom_range(0, 70));
        end else begin
            ch[0] = 8'($urandom_range(0, 255));
            ch[1] = clamp_channel(int'(ch[0]) + $urandom_range(0, 20) - 10);
            ch[2] = clamp_channel(int'(ch[0]) + $urandom_range(0, 20) - 10);
        end
        return {ch[2], ch[1], ch[0]};
    endfunction

    function automatic int draw_wait(ref int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            burst = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic send_pair(input logic [23:0] fore, input logic [23:0] back,
                             input logic typed, input logic [3:0] typed_fore,
                             input logic [3:0] typed_back);
        int gap;
        t_attr_result res;
        gap = draw_wait(send_burst);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {back, fore};
        do @(posedge i_clk); while (!s_tready);
        res.fore_slot = typed ? typed_fore : nearest_slot(fore);
        res.back_slot = typed ? typed_back : nearest_slot(back);
        res.attribute = {res.back_slot[2:0], res.fore_slot};
        pending_attrs.push_back(res);
        @(negedge i_clk);
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (int n = 0; n < NUM_DIRECTED; n++)
            send_pair(DIRECTED[n].fore, DIRECTED[n].back, DIRECTED[n].typed,
                      DIRECTED[n].fore_slot, DIRECTED[n].back_slot);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                // hold until the pipeline drains
                s_tvalid <= 1'b0;
                while (pending_attrs.size() != 0) @(negedge i_clk);
                @(negedge i_clk);
            end
            send_pair(random_color(), random_color(), 1'b0, 4'd0, 4'd0);
        end
        s_tvalid <= 1'b0;
        while (pending_attrs.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_attrs.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_attrs.size()));
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        int stall;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            stall = draw_wait(recv_burst);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_attr_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_attrs.size() == 0) begin
                report_mismatch($sformatf("unexpected item tdata=%h", m_tdata));
            end else begin
                want = pending_attrs.pop_front();
                if (m_tdata[6:0] !== want.attribute)
                    report_mismatch($sformatf("attribute got %h want %h",
                                              m_tdata[6:0], want.attribute));
                if (m_tdata[10:7] !== want.fore_slot)
                    report_mismatch($sformatf("fore_slot got %0d want %0d",
                                              m_tdata[10:7], want.fore_slot));
                if (m_tdata[14:11] !== want.back_slot)
                    report_mismatch($sformatf("back_slot got %0d want %0d",
                                              m_tdata[14:11], want.back_slot));
                if (m_tdata[15] !== 1'b0)
                    report_mismatch("pad bit 15 not zero");
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
        $display("status: fail");
        $finish;
    end

endmodule
